[hw/rtl/assert_macros.svh]
// assertion macros shared by the checker files
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define DWC_ASSERT_NOW(lbl, clk, rstn, a, c, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (a) |-> (c)) else $error(msg);

// next-cycle implication
`define DWC_ASSERT_NEXT(lbl, clk, rstn, a, c, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (a) |=> (c)) else $error(msg);

`endif

[hw/rtl/dwc_pkg.sv]
// types, constants and helper functions of the automaton word counter
// no dependencies
`default_nettype none
package dwc_pkg;
    localparam int NUM_STATES = 64;
    localparam int ALPHABET   = 26;
    localparam int ST_W       = $clog2(NUM_STATES);
    localparam int LT_W       = 5;
    localparam int LEN_W      = 16;
    localparam int CNT_W      = 30;
    localparam int TT_DEPTH   = NUM_STATES * ALPHABET;
    localparam int TT_AW      = $clog2(TT_DEPTH);
    localparam int VEC_AW     = ST_W + 1;
    localparam logic [ST_W-1:0]  SINK    = ST_W'(NUM_STATES - 1);
    localparam logic [CNT_W-1:0] MODULUS = CNT_W'(1000000007);

    typedef enum logic [1:0] {
        MODE_LINK  = 2'd0,
        MODE_TERM  = 2'd1,
        MODE_FEED  = 2'd2,
        MODE_QUERY = 2'd3
    } mode_t;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_EXEC, ST_WALK_UPD, ST_PUT_ACC, ST_INIT, ST_ZERO,
        ST_ROW, ST_ROW_CHK, ST_EDGE, ST_NXT_RD, ST_NXT_WR, ST_FLIP, ST_SUM_RD,
        ST_SUM_ADD, ST_PUT_CNT
    } state_t;

    typedef struct packed {
        logic load_item;
        logic clr_step;
        logic link_wr;
        logic term_wr;
        logic walk_rd;
        logic walk_upd;
        logic vec_init;
        logic vec_zero;
        logic row_rd;
        logic row_chk;
        logic edge_rd;
        logic nxt_rd;
        logic nxt_wr;
        logic flip;
        logic sum_rd;
        logic sum_add;
        logic res_walk;
        logic res_count;
    } cmd_t;

    typedef struct packed {
        mode_t mode;
        logic  last;
        logic  clr_last;
        logic  j_last;
        logic  i_last;
        logic  a_last;
        logic  v_zero;
        logic  len_zero;
        logic  len_one;
        logic  out_busy;
    } status_t;

    function automatic logic [TT_AW-1:0] tt_addr(input logic [ST_W-1:0] s,
                                                 input logic [LT_W-1:0] l);
        logic [TT_AW-1:0] base;
        base = TT_AW'(s) * TT_AW'(ALPHABET);
        return base + TT_AW'(l);
    endfunction

    function automatic logic [CNT_W-1:0] mod_add(input logic [CNT_W-1:0] a,
                                                 input logic [CNT_W-1:0] b);
        logic [CNT_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        if (sum >= {1'b0, MODULUS}) begin
            sum = sum - {1'b0, MODULUS};
        end
        return sum[CNT_W-1:0];
    endfunction
endpackage
`default_nettype wire

[hw/rtl/dwc_ctrl.sv]
// controller state machine of the automaton word counter
// depends on dwc_pkg
`default_nettype none
module dwc_ctrl
    import dwc_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    s_valid,
    output logic         s_ready,
    input  wire status_t status,
    output cmd_t         cmd
);
    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:    if (status.clr_last) state_next = ST_IDLE;
            ST_IDLE:     if (s_valid) state_next = ST_EXEC;
            ST_EXEC: begin
                case (status.mode)
                    MODE_FEED:  state_next = ST_WALK_UPD;
                    MODE_QUERY: state_next = ST_INIT;
                    default:    state_next = ST_IDLE;
                endcase
            end
            ST_WALK_UPD: state_next = status.last ? ST_PUT_ACC : ST_IDLE;
            ST_PUT_ACC:  if (!status.out_busy) state_next = ST_IDLE;
            ST_INIT: begin
                if (status.j_last) state_next = status.len_zero ? ST_SUM_RD : ST_ZERO;
            end
            ST_ZERO:     if (status.j_last) state_next = ST_ROW;
            ST_ROW:      state_next = ST_ROW_CHK;
            ST_ROW_CHK: begin
                if (!status.v_zero) state_next = ST_EDGE;
                else state_next = status.i_last ? ST_FLIP : ST_ROW;
            end
            ST_EDGE:     state_next = ST_NXT_RD;
            ST_NXT_RD:   state_next = ST_NXT_WR;
            ST_NXT_WR: begin
                if (!status.a_last) state_next = ST_EDGE;
                else state_next = status.i_last ? ST_FLIP : ST_ROW;
            end
            ST_FLIP:     state_next = status.len_one ? ST_SUM_RD : ST_ZERO;
            ST_SUM_RD:   state_next = ST_SUM_ADD;
            ST_SUM_ADD:  state_next = status.j_last ? ST_PUT_CNT : ST_SUM_RD;
            ST_PUT_CNT:  if (!status.out_busy) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        case (state_reg)
            ST_CLEAR:    cmd.clr_step = 1'b1;
            ST_IDLE: begin
                s_ready       = 1'b1;
                cmd.load_item = s_valid;
            end
            ST_EXEC: begin
                cmd.link_wr = (status.mode == MODE_LINK);
                cmd.term_wr = (status.mode == MODE_TERM);
                cmd.walk_rd = (status.mode == MODE_FEED);
            end
            ST_WALK_UPD: cmd.walk_upd  = 1'b1;
            ST_PUT_ACC:  cmd.res_walk  = !status.out_busy;
            ST_INIT:     cmd.vec_init  = 1'b1;
            ST_ZERO:     cmd.vec_zero  = 1'b1;
            ST_ROW:      cmd.row_rd    = 1'b1;
            ST_ROW_CHK:  cmd.row_chk   = 1'b1;
            ST_EDGE:     cmd.edge_rd   = 1'b1;
            ST_NXT_RD:   cmd.nxt_rd    = 1'b1;
            ST_NXT_WR:   cmd.nxt_wr    = 1'b1;
            ST_FLIP:     cmd.flip      = 1'b1;
            ST_SUM_RD:   cmd.sum_rd    = 1'b1;
            ST_SUM_ADD:  cmd.sum_add   = 1'b1;
            ST_PUT_CNT:  cmd.res_count = !status.out_busy;
            default:     cmd = '0;
        endcase
    end
endmodule
`default_nettype wire

[hw/rtl/dwc_datapath.sv]
// datapath: transition memory, count vector memory, counters, output register
// depends on dwc_pkg
`default_nettype none
module dwc_datapath
    import dwc_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire cmd_t              cmd,
    output status_t                status,
    input  wire logic              cfg_valid,
    input  wire logic [ST_W-1:0]   cfg_start_state,
    input  wire logic [1:0]        s_mode,
    input  wire logic [ST_W-1:0]   s_from_state,
    input  wire logic [ST_W-1:0]   s_to_state,
    input  wire logic [LT_W-1:0]   s_letter,
    input  wire logic              s_first_symbol,
    input  wire logic              s_last_symbol,
    input  wire logic [LEN_W-1:0]  s_word_length,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic                   m_result_kind,
    output logic                   m_accepted,
    output logic [CNT_W-1:0]       m_word_count
);
    logic [ST_W-1:0]   tt_mem [TT_DEPTH];
    logic [CNT_W-1:0]  vec_mem [2*NUM_STATES];

    logic [ST_W-1:0]   start_reg;
    logic [1:0]        mode_reg;
    logic [ST_W-1:0]   from_reg, to_reg, walk_reg, t_reg;
    logic [LT_W-1:0]   letter_reg;
    logic              first_reg, last_reg, sel_reg;
    logic [LEN_W-1:0]  len_reg;
    logic [TT_AW-1:0]  clr_reg;
    logic [ST_W-1:0]   i_reg, j_reg;
    logic [LT_W-1:0]   a_reg;
    logic [CNT_W-1:0]  v_reg, acc_reg;
    logic [NUM_STATES-1:0] term_reg;
    logic [ST_W-1:0]   tq;
    logic [CNT_W-1:0]  vq;
    logic              valid_reg, kind_reg, acc_bit_reg;
    logic [CNT_W-1:0]  count_reg;

    logic              letter_ok;
    logic [ST_W-1:0]   walk_src;
    logic [TT_AW-1:0]  tt_raddr;
    logic [VEC_AW-1:0] vec_raddr, vec_waddr;
    logic [CNT_W-1:0]  vec_wdata;
    logic              vec_we;

    assign letter_ok = (letter_reg < LT_W'(ALPHABET));
    assign walk_src  = first_reg ? start_reg : walk_reg;

    always_comb begin
        tt_raddr = tt_addr(i_reg, a_reg);
        if (cmd.walk_rd) begin
            tt_raddr = tt_addr(walk_src, letter_ok ? letter_reg : '0);
        end
    end

    always_comb begin
        vec_raddr = {sel_reg, i_reg};
        if (cmd.nxt_rd) vec_raddr = {~sel_reg, tq};
        if (cmd.sum_rd) vec_raddr = {sel_reg, j_reg};
    end

    always_comb begin
        vec_we    = cmd.vec_init | cmd.vec_zero | cmd.nxt_wr;
        vec_waddr = {~sel_reg, t_reg};
        vec_wdata = mod_add(vq, v_reg);
        if (cmd.vec_init) begin
            vec_waddr = {sel_reg, j_reg};
            vec_wdata = (j_reg == start_reg) ? CNT_W'(1) : '0;
        end else if (cmd.vec_zero) begin
            vec_waddr = {~sel_reg, j_reg};
            vec_wdata = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.clr_step) begin
            tt_mem[clr_reg] <= SINK;
        end else if (cmd.link_wr && letter_ok) begin
            tt_mem[tt_addr(from_reg, letter_reg)] <= to_reg;
        end
        tq <= tt_mem[tt_raddr];
        if (vec_we) begin
            vec_mem[vec_waddr] <= vec_wdata;
        end
        vq <= vec_mem[vec_raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_reg <= '0;
            walk_reg  <= '0;
            term_reg  <= '0;
            clr_reg   <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
            a_reg     <= '0;
            sel_reg   <= 1'b0;
            valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) start_reg <= cfg_start_state;
            if (cmd.clr_step) clr_reg <= clr_reg + 1'b1;
            if (cmd.term_wr) term_reg[from_reg] <= 1'b1;
            if (cmd.walk_upd) walk_reg <= letter_ok ? tq : SINK;
            if (cmd.vec_init || cmd.vec_zero || cmd.sum_add) j_reg <= j_reg + 1'b1;
            if ((cmd.row_chk && vq == '0) || (cmd.nxt_wr && status.a_last)) begin
                i_reg <= i_reg + 1'b1;
            end
            if (cmd.nxt_wr) a_reg <= status.a_last ? '0 : a_reg + 1'b1;
            if (cmd.flip) sel_reg <= ~sel_reg;
            if (cmd.res_walk || cmd.res_count) begin
                valid_reg <= 1'b1;
            end else if (m_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            mode_reg   <= s_mode;
            from_reg   <= s_from_state;
            to_reg     <= s_to_state;
            letter_reg <= s_letter;
            first_reg  <= s_first_symbol;
            last_reg   <= s_last_symbol;
            len_reg    <= s_word_length;
            acc_reg    <= '0;
        end
        if (cmd.flip) len_reg <= len_reg - 1'b1;
        if (cmd.row_chk) v_reg <= vq;
        if (cmd.nxt_rd) t_reg <= tq;
        if (cmd.sum_add) acc_reg <= mod_add(acc_reg, term_reg[j_reg] ? vq : '0);
        if (cmd.res_walk) begin
            kind_reg    <= 1'b0;
            acc_bit_reg <= term_reg[walk_reg];
            count_reg   <= '0;
        end else if (cmd.res_count) begin
            kind_reg    <= 1'b1;
            acc_bit_reg <= 1'b0;
            count_reg   <= acc_reg;
        end
    end

    always_comb begin
        status.mode     = mode_t'(mode_reg);
        status.last     = last_reg;
        status.clr_last = (clr_reg == TT_AW'(TT_DEPTH - 1));
        status.j_last   = (j_reg == SINK);
        status.i_last   = (i_reg == SINK);
        status.a_last   = (a_reg == LT_W'(ALPHABET - 1));
        status.v_zero   = (vq == '0);
        status.len_zero = (len_reg == '0);
        status.len_one  = (len_reg == LEN_W'(1));
        status.out_busy = valid_reg;
    end

    assign m_valid       = valid_reg;
    assign m_result_kind = kind_reg;
    assign m_accepted    = acc_bit_reg;
    assign m_word_count  = count_reg;
endmodule
`default_nettype wire

[hw/rtl/dfa_word_count_mod_prime_core.sv]
// Automaton over 26 letters that checks strings and counts accepted words.
// Input channel s_*: one transaction per item (link, mark terminal, feed
// symbol, count query). Result channel m_*: an acceptance answer for a
// symbol with last set, a count answer for every query. Config channel
// cfg_*: start state, always ready; it must be written only while idle,
// which the block does not enforce. Link and terminal items are stored
// in EXEC; a symbol is looked up in EXEC, its walk state set in WALK_UPD.
// A count query steps the count vector once per unit of length, adding
// each nonzero count along all 26 letters, then sums terminal counts.
// At reset a clearing pass writes the sink into all 1664 transition entries;
// s_ready stays low until that pass is done.
// A result waits in the output register while m_ready is low; items that
// give no result are still taken, a result-giving item waits for the slot.
// depends on dwc_pkg, dwc_ctrl, dwc_datapath
`default_nettype none
module dfa_word_count_mod_prime_core
    import dwc_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [ST_W-1:0]   cfg_start_state,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [1:0]        s_mode,
    input  wire logic [ST_W-1:0]   s_from_state,
    input  wire logic [ST_W-1:0]   s_to_state,
    input  wire logic [LT_W-1:0]   s_letter,
    input  wire logic              s_first_symbol,
    input  wire logic              s_last_symbol,
    input  wire logic [LEN_W-1:0]  s_word_length,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic                   m_result_kind,
    output logic                   m_accepted,
    output logic [CNT_W-1:0]       m_word_count
);
    cmd_t    cmd;
    status_t status;

    assign cfg_ready = 1'b1;

    dwc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    dwc_datapath u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .status          (status),
        .cfg_valid       (cfg_valid),
        .cfg_start_state (cfg_start_state),
        .s_mode          (s_mode),
        .s_from_state    (s_from_state),
        .s_to_state      (s_to_state),
        .s_letter        (s_letter),
        .s_first_symbol  (s_first_symbol),
        .s_last_symbol   (s_last_symbol),
        .s_word_length   (s_word_length),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_result_kind   (m_result_kind),
        .m_accepted      (m_accepted),
        .m_word_count    (m_word_count)
    );
endmodule
`default_nettype wire

[hw/rtl/dwc_checker.sv]
// port-level checks of the automaton word counter, bound to the top level
// depends on assert_macros.svh, dwc_pkg, dfa_word_count_mod_prime_core
`default_nettype none
`include "assert_macros.svh"
module dwc_checker
    import dwc_pkg::*;
(
    input wire logic             aclk,
    input wire logic             aresetn,
    input wire logic             s_valid,
    input wire logic             s_ready,
    input wire logic             m_valid,
    input wire logic             m_ready,
    input wire logic [CNT_W-1:0] m_word_count
);
    `DWC_ASSERT_NEXT(a_rst_no_result, aclk, 1'b1, !aresetn, !m_valid, "result after reset")
    `DWC_ASSERT_NEXT(a_rst_clearing, aclk, 1'b1, !aresetn, !s_ready, "ready during clearing")
    `DWC_ASSERT_NEXT(a_busy_after_in, aclk, aresetn, s_valid && s_ready, !s_ready, "not busy")
    `DWC_ASSERT_NEXT(a_gap_after_out, aclk, aresetn, m_valid && m_ready, !m_valid, "no gap")
    `DWC_ASSERT_NEXT(a_hold_out, aclk, aresetn, m_valid && !m_ready,
        m_valid && $stable(m_word_count), "stalled result changed")
endmodule

bind dfa_word_count_mod_prime_core dwc_checker u_dwc_checker (.*);
`default_nettype wire

[bench/dfa_word_count_mod_prime_core_test.sv]
// self-checking bench for dfa_word_count_mod_prime_core: directed table, then random phases
// keeps its own automaton model and compares every answer; depends on dwc_pkg and the core
`timescale 1ns / 100ps
`default_nettype none
module dfa_word_count_mod_prime_core_test;
    import dwc_pkg::*;

    localparam int MOD_P = 1000000007;
    localparam int CYCLE_LIMIT = 6000000;

    typedef struct {
        mode_t       mode;
        logic [5:0]  from_st;
        logic [5:0]  to_st;
        logic [4:0]  letter;
        logic        first;
        logic        last;
        logic [15:0] len;
        logic        typed;
        logic        kind;
        logic        acc;
        logic [29:0] cnt;
    } stim_row_t;

    typedef struct packed {
        logic        kind;
        logic        acc;
        logic [29:0] cnt;
    } answer_t;

    logic              aclk;
    logic              aresetn;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [ST_W-1:0]   cfg_start_state;
    logic              s_valid;
    logic              s_ready;
    logic [1:0]        s_mode;
    logic [ST_W-1:0]   s_from_state;
    logic [ST_W-1:0]   s_to_state;
    logic [LT_W-1:0]   s_letter;
    logic              s_first_symbol;
    logic              s_last_symbol;
    logic [LEN_W-1:0]  s_word_length;
    logic              m_valid;
    logic              m_ready;
    logic              m_result_kind;
    logic              m_accepted;
    logic [CNT_W-1:0]  m_word_count;

    // automaton mirror
    logic [5:0] next_st [64][26];
    logic [4:0] edge_cnt [64][64];
    bit         is_term [64];
    logic [5:0] walk_st;
    logic [5:0] start_st;

    answer_t pending_answers[$];
    int      mismatches;
    int      cycle_cnt;
    int      stall_left;
    bit      no_idle;

    dfa_word_count_mod_prime_core u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_start_state (cfg_start_state),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_mode          (s_mode),
        .s_from_state    (s_from_state),
        .s_to_state      (s_to_state),
        .s_letter        (s_letter),
        .s_first_symbol  (s_first_symbol),
        .s_last_symbol   (s_last_symbol),
        .s_word_length   (s_word_length),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_result_kind   (m_result_kind),
        .m_accepted      (m_accepted),
        .m_word_count    (m_word_count)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic int idle_cycles();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(5, 40);
    endfunction

    function automatic logic [29:0] count_accepted(input int len);
        longint vec [64];
        longint acc [64];
        longint total;
        for (int i = 0; i < 64; i++) vec[i] = 0;
        vec[start_st] = 1;
        for (int d = 0; d < len; d++) begin
            for (int j = 0; j < 64; j++) acc[j] = 0;
            for (int i = 0; i < 64; i++) begin
                if (vec[i] != 0) begin
                    for (int j = 0; j < 64; j++) acc[j] += longint'(edge_cnt[i][j]) * vec[i];
                end
            end
            for (int j = 0; j < 64; j++) vec[j] = acc[j] % MOD_P;
        end
        total = 0;
        for (int i = 0; i < 64; i++) if (is_term[i]) total += vec[i];
        return 30'(total % MOD_P);
    endfunction

    // updates the mirror, returns 1 when the item yields an answer
    function automatic bit predict_answer(input stim_row_t it, output answer_t ans);
        logic [5:0] s;
        logic [5:0] old;
        ans = '0;
        case (it.mode)
            MODE_LINK: begin
                if (it.letter < 26) begin
                    old = next_st[it.from_st][it.letter];
                    edge_cnt[it.from_st][it.to_st] += 1;
                    edge_cnt[it.from_st][old] -= 1;
                    next_st[it.from_st][it.letter] = it.to_st;
                end
                return 0;
            end
            MODE_TERM: begin
                is_term[it.from_st] = 1;
                return 0;
            end
            MODE_FEED: begin
                s = it.first ? start_st : walk_st;
                s = (it.letter < 26) ? next_st[s][it.letter] : SINK;
                walk_st = s;
                if (!it.last) return 0;
                ans.acc = is_term[s];
                return 1;
            end
            default: begin
                ans.kind = 1'b1;
                ans.cnt = count_accepted(it.len);
                return 1;
            end
        endcase
    endfunction

    task automatic send_item(input stim_row_t it);
        int gap;
        answer_t ans;
        bit has_ans;
        gap = idle_cycles();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_mode         <= it.mode;
        s_from_state   <= it.from_st;
        s_to_state     <= it.to_st;
        s_letter       <= it.letter;
        s_first_symbol <= it.first;
        s_last_symbol  <= it.last;
        s_word_length  <= it.len;
        do @(posedge aclk); while (!s_ready);
        has_ans = predict_answer(it, ans);
        if (it.typed) begin
            ans.kind = it.kind;
            ans.acc  = it.acc;
            ans.cnt  = it.cnt;
        end
        if (has_ans) pending_answers.push_back(ans);
    endtask

    task automatic load_start_state(input logic [5:0] st);
        s_valid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge aclk);
        repeat (30) @(posedge aclk);
        cfg_valid       <= 1'b1;
        cfg_start_state <= st;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        start_st = st;
    endtask

    function automatic logic [5:0] pick_state();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) return 6'($urandom_range(0, 7));
        if (r < 90) return SINK;
        return 6'($urandom_range(0, 63));
    endfunction

    function automatic stim_row_t blank_row(input mode_t m);
        stim_row_t it;
        it.mode    = m;
        it.from_st = 6'($urandom);
        it.to_st   = 6'($urandom);
        it.letter  = 5'($urandom);
        it.first   = 1'($urandom);
        it.last    = 1'($urandom);
        it.len     = 16'($urandom);
        it.typed   = 1'b0;
        it.kind    = 1'b0;
        it.acc     = 1'b0;
        it.cnt     = '0;
        return it;
    endfunction

    task automatic random_phase(input int n_items);
        int sent;
        int r;
        int slen;
        stim_row_t it;
        sent = 0;
        while (sent < n_items) begin
            r = $urandom_range(0, 99);
            if (r < 30) begin
                it = blank_row(MODE_LINK);
                it.from_st = pick_state();
                it.to_st   = pick_state();
                if ($urandom_range(0, 9) != 0) it.letter = 5'($urandom_range(0, 25));
                send_item(it);
                sent++;
            end else if (r < 38) begin
                it = blank_row(MODE_TERM);
                it.from_st = pick_state();
                send_item(it);
                sent++;
            end else if (r < 85) begin
                // symbol string, sometimes broken
                slen = $urandom_range(1, 5);
                for (int k = 0; k < slen; k++) begin
                    it = blank_row(MODE_FEED);
                    if ($urandom_range(0, 9) != 0) it.letter = 5'($urandom_range(0, 25));
                    it.first = (k == 0);
                    it.last  = (k == slen - 1);
                    if ($urandom_range(0, 9) == 0) it.first = ~it.first;
                    if ($urandom_range(0, 9) == 0) it.last = ~it.last;
                    send_item(it);
                    sent++;
                end
            end else begin
                it = blank_row(MODE_QUERY);
                it.len = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(5, 12))
                                                     : 16'($urandom_range(0, 4));
                send_item(it);
                sent++;
            end
        end
    endtask

    // result side stalls
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            if (!no_idle && $urandom_range(0, 99) < 25) stall_left <= idle_cycles();
        end
    end

    always @(posedge aclk) begin
        answer_t exp_ans;
        if (aresetn && m_valid && m_ready) begin
            if (pending_answers.size() == 0) begin
                $display("%0t: unexpected transaction kind=%0d acc=%0d cnt=%0d", $time,
                         m_result_kind, m_accepted, m_word_count);
                mismatches++;
            end else begin
                exp_ans = pending_answers.pop_front();
                if (m_result_kind !== exp_ans.kind) begin
                    $display("%0t: result_kind expected %0d actual %0d", $time,
                             exp_ans.kind, m_result_kind);
                    mismatches++;
                end
                if (m_accepted !== exp_ans.acc) begin
                    $display("%0t: accepted expected %0d actual %0d", $time,
                             exp_ans.acc, m_accepted);
                    mismatches++;
                end
                if (m_word_count !== exp_ans.cnt) begin
                    $display("%0t: word_count expected %0d actual %0d", $time,
                             exp_ans.cnt, m_word_count);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        stim_row_t dir_rows [22];
        logic [5:0] starts [7];
        dir_rows = '{
            '{MODE_QUERY, 0, 0, 0, 0, 0, 0, 1, 1, 0, 0},
            '{MODE_QUERY, 0, 0, 0, 0, 0, 1, 1, 1, 0, 0},
            '{MODE_TERM, 63, 0, 31, 1, 1, 16'hFFFF, 0, 0, 0, 0},
            '{MODE_QUERY, 0, 0, 0, 0, 0, 0, 1, 1, 0, 0},
            '{MODE_QUERY, 0, 0, 0, 0, 0, 1, 1, 1, 0, 26},
            '{MODE_QUERY, 0, 0, 0, 0, 0, 2, 1, 1, 0, 676},
            '{MODE_FEED, 0, 0, 0, 1, 1, 0, 1, 0, 1, 0},
            '{MODE_FEED, 63, 63, 31, 1, 1, 16'hFFFF, 1, 0, 1, 0},
            '{MODE_LINK, 0, 5, 0, 0, 0, 0, 0, 0, 0, 0},
            '{MODE_LINK, 0, 63, 31, 1, 1, 16'hFFFF, 0, 0, 0, 0},
            '{MODE_FEED, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0},
            '{MODE_FEED, 0, 0, 1, 0, 1, 0, 1, 0, 1, 0},
            '{MODE_TERM, 5, 0, 0, 0, 0, 0, 0, 0, 0, 0},
            '{MODE_FEED, 0, 0, 0, 1, 1, 0, 1, 0, 1, 0},
            '{MODE_QUERY, 0, 0, 0, 0, 0, 1, 1, 1, 0, 26},
            '{MODE_LINK, 63, 0, 25, 0, 0, 0, 0, 0, 0, 0},
            '{MODE_LINK, 5, 5, 25, 0, 0, 0, 0, 0, 0, 0},
            '{MODE_QUERY, 0, 0, 0, 0, 0, 2, 0, 0, 0, 0},
            '{MODE_FEED, 0, 0, 25, 0, 1, 0, 0, 0, 0, 0},
            '{MODE_LINK, 0, 62, 25, 0, 0, 0, 0, 0, 0, 0},
            '{MODE_QUERY, 0, 0, 0, 0, 0, 3, 0, 0, 0, 0},
            '{MODE_LINK, 62, 63, 0, 0, 0, 0, 0, 0, 0, 0}
        };
        starts = '{6'd0, SINK, 6'd5, 6'd0, 6'd62, 6'd3, SINK};
        aresetn = 1'b0;
        cfg_valid = 1'b0;
        cfg_start_state = '0;
        s_valid = 1'b0;
        s_mode = MODE_LINK;
        s_from_state = '0;
        s_to_state = '0;
        s_letter = '0;
        s_first_symbol = 1'b0;
        s_last_symbol = 1'b0;
        s_word_length = '0;
        m_ready = 1'b0;
        mismatches = 0;
        cycle_cnt = 0;
        stall_left = 0;
        no_idle = 1'b0;
        for (int i = 0; i < 64; i++) begin
            is_term[i] = 0;
            for (int l = 0; l < 26; l++) next_st[i][l] = SINK;
            for (int j = 0; j < 64; j++) edge_cnt[i][j] = (j == SINK) ? 5'd26 : 5'd0;
        end
        walk_st = '0;
        start_st = '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        foreach (dir_rows[i]) send_item(dir_rows[i]);
        foreach (starts[p]) begin
            load_start_state(starts[p]);
            no_idle = (p == 3);
            random_phase(16);
        end
        s_valid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
`default_nettype wire
